@@ hw/rtl/bcr_pkg.sv @@
package bcr_pkg;

    // Field widths
    localparam int SAT_BITS = 16;
    localparam int CFG_W    = (SAT_BITS > 16) ? SAT_BITS : 16;
    localparam int EXP_W    = 26;               // Q.12 exponent, wide enough for the legacy one
    localparam int X_W      = 17;               // Q0.16 value in [0, 1.0]
    localparam int NUM_W    = SAT_BITS + 17;    // saturation dividend
    localparam int DEN_W    = SAT_BITS + 1;     // saturation divisor

    // Pipeline depths
    localparam int DIV_STAGES = 16;
    localparam int POW_LAT    = 36;

    // Fixed-point constants
    localparam logic [X_W-1:0] ONE16   = X_W'(65536);
    localparam logic [15:0]    ONE15   = 16'd32768;
    localparam logic [15:0]    EXP_RST = 16'd8192;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_WET_EXP    = 3'd0,
        CFG_NONWET_EXP = 3'd1,
        CFG_RESID      = 3'd2,
        CFG_WET_END    = 3'd3,
        CFG_NONWET_END = 3'd4,
        CFG_LEGACY     = 3'd5
    } t_cfg_idx;

    // Integer square root, bit by bit
    function automatic logic [63:0] f_isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = '0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + b) begin
                v   = v - res - b;
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Factor 2^(-2^-j) in Q0.32 by repeated square roots of one half
    function automatic logic [31:0] f_exp_coef(input int j);
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int i = 1; i <= 16; i++) begin
            if (i <= j) begin
                c = f_isqrt(c << 32);
            end
        end
        return c[31:0];
    endfunction

endpackage

@@ hw/rtl/bcr_sat_if.sv @@
interface bcr_sat_if;
    logic                         valid;
    logic                         ready;
    logic [bcr_pkg::SAT_BITS-1:0] saturation;

    modport source (output valid, output saturation, input ready);
    modport sink   (input valid, input saturation, output ready);
endinterface

@@ hw/rtl/bcr_perm_if.sv @@
interface bcr_perm_if;
    logic        valid;
    logic        ready;
    logic [15:0] perm_wet;
    logic [15:0] perm_nonwet;

    modport source (output valid, output perm_wet, output perm_nonwet, input ready);
    modport sink   (input valid, input perm_wet, input perm_nonwet, output ready);
endinterface

@@ hw/rtl/brooks_corey_relperm.sv @@
// Brooks-Corey relative permeability pipeline.
// Throughput: one beat per cycle while the output buffer is not full or the
// port is ready; the divider (16 stages) and the two power units (36 stages
// each) are fully pipelined, a 2-entry output buffer absorbs downstream
// stalls. Reset (synchronous, active low) empties the pipeline and buffer and
// loads the default registers.
module brooks_corey_relperm (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [bcr_pkg::CFG_W-1:0]     i_cfg_data,
    bcr_sat_if.sink                       i_sat,
    bcr_perm_if.source                    o_perm
);
    localparam int SB    = bcr_pkg::SAT_BITS;
    localparam int XW    = bcr_pkg::X_W;
    localparam int EW    = bcr_pkg::EXP_W;
    localparam int PL    = bcr_pkg::POW_LAT;
    localparam int DEPTH = 1 + bcr_pkg::DIV_STAGES + 1 + PL + 1;

    // Scale a Q0.16 factor by a Q1.15 endpoint, saturated to one
    function automatic logic [15:0] f_scale(input logic [15:0] e, input logic [XW-1:0] p);
        logic [15:0] ce;
        logic [32:0] v;
        ce = (e > bcr_pkg::ONE15) ? bcr_pkg::ONE15 : e;
        v  = {17'd0, ce} * {16'd0, p} + 33'd32768;
        return (v[32:16] > 17'(bcr_pkg::ONE15)) ? bcr_pkg::ONE15 : v[31:16];
    endfunction

    // Configuration registers
    logic [15:0]   r_wet_exp;
    logic [15:0]   r_nonwet_exp;
    logic [SB-1:0] r_resid;
    logic [15:0]   r_wet_end;
    logic [15:0]   r_nonwet_end;
    logic          r_legacy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wet_exp    <= bcr_pkg::EXP_RST;
            r_nonwet_exp <= bcr_pkg::EXP_RST;
            r_resid      <= '0;
            r_wet_end    <= bcr_pkg::ONE15;
            r_nonwet_end <= bcr_pkg::ONE15;
            r_legacy     <= 1'b0;
        end else if (i_cfg_we) begin
            case (bcr_pkg::t_cfg_idx'(i_cfg_idx))
                bcr_pkg::CFG_WET_EXP:    r_wet_exp    <= i_cfg_data[15:0];
                bcr_pkg::CFG_NONWET_EXP: r_nonwet_exp <= i_cfg_data[15:0];
                bcr_pkg::CFG_RESID:      r_resid      <= i_cfg_data[SB-1:0];
                bcr_pkg::CFG_WET_END:    r_wet_end    <= i_cfg_data[15:0];
                bcr_pkg::CFG_NONWET_END: r_nonwet_end <= i_cfg_data[15:0];
                bcr_pkg::CFG_LEGACY:     r_legacy     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline advance and output buffer control
    logic [1:0] r_cnt;
    logic       w_en;
    logic       w_push;
    logic       w_pop;
    assign w_en        = (r_cnt != 2'd2) || o_perm.ready;
    assign i_sat.ready = w_en;

    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] r_le;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_sat.valid};
        end
    end

    // Stage A: below-residual flag and dividend/divisor
    logic [SB-1:0]             w_diff;
    logic [SB:0]               w_den;
    logic [bcr_pkg::NUM_W-1:0] r_a_num;
    logic [SB:0]               r_a_den;
    assign w_diff = i_sat.saturation - r_resid;
    assign w_den  = {1'b1, SB'(0)} - {1'b0, r_resid};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_le    <= {r_le[DEPTH-2:0], (i_sat.saturation <= r_resid)};
            r_a_num <= {1'b0, w_diff, 16'd0} + bcr_pkg::NUM_W'(w_den >> 1);
            r_a_den <= w_den;
        end
    end

    // Normalized saturation and legacy exponent
    logic [15:0]   w_s;
    logic [EW-1:0] w_q;
    bcr_div u_div (
        .i_clk        (i_clk),
        .i_en         (w_en),
        .i_num        (r_a_num),
        .i_den        (r_a_den),
        .i_nonwet_exp (r_nonwet_exp),
        .o_s          (w_s),
        .o_q          (w_q)
    );

    // Stage B: hold s and q for the power units, add one to the legacy exponent
    logic [15:0]   r_b_s;
    logic [EW-1:0] r_b_q;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_s <= w_s;
            r_b_q <= w_q + EW'(4096);
        end
    end

    logic [XW-1:0] w_sx;
    logic [XW-1:0] w_u;
    logic [33:0]   w_u2;
    assign w_sx = {1'b0, r_b_s};
    assign w_u  = bcr_pkg::ONE16 - w_sx;
    assign w_u2 = {17'd0, w_u} * {17'd0, w_u} + 34'd32768;

    // Carry (1-s)^2 alongside the power units
    logic [XW-1:0] r_u2 [PL];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u2[0] <= w_u2[32:16];
            for (int i = 1; i < PL; i++) begin
                r_u2[i] <= r_u2[i-1];
            end
        end
    end

    logic [XW-1:0] w_x2;
    logic [EW-1:0] w_e2;
    logic [XW-1:0] w_pw;
    logic [XW-1:0] w_pn2;
    assign w_x2 = r_legacy ? w_sx  : w_u;
    assign w_e2 = r_legacy ? r_b_q : {(EW - 16)'(0), r_nonwet_exp};

    bcr_pow u_pow_wet (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (w_sx),
        .i_e   ({(EW - 16)'(0), r_wet_exp}),
        .o_y   (w_pw)
    );

    bcr_pow u_pow_nonwet (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (w_x2),
        .i_e   (w_e2),
        .o_y   (w_pn2)
    );

    // Stage C: wet result and non-wetting factor
    logic [XW-1:0] w_sq2;
    logic [XW-1:0] w_om;
    logic [33:0]   w_lp;
    logic [15:0]   r_c_wet;
    logic [XW-1:0] r_c_pn;
    assign w_sq2 = (r_nonwet_exp == '0) ? '0 : w_pn2;
    assign w_om  = bcr_pkg::ONE16 - w_sq2;
    assign w_lp  = {17'd0, r_u2[PL-1]} * {17'd0, w_om} + 34'd32768;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_wet <= f_scale(r_wet_end, w_pw);
            r_c_pn  <= r_legacy ? w_lp[32:16] : w_pn2;
        end
    end

    // Final results, overridden at or below residual saturation
    logic [15:0] w_res_wet;
    logic [15:0] w_res_nonwet;
    assign w_res_wet    = r_le[DEPTH-1] ? 16'd0 : r_c_wet;
    assign w_res_nonwet = r_le[DEPTH-1] ? f_scale(r_nonwet_end, bcr_pkg::ONE16)
                                        : f_scale(r_nonwet_end, r_c_pn);

    // Output buffer: two entries, head drives the port
    logic [15:0] r_q0_wet;
    logic [15:0] r_q0_nonwet;
    logic [15:0] r_q1_wet;
    logic [15:0] r_q1_nonwet;
    assign w_push = r_vld[DEPTH-1] && w_en;
    assign w_pop  = o_perm.valid && o_perm.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_push && !w_pop) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push && w_pop) begin
            if (r_cnt == 2'd1) begin
                r_q0_wet    <= w_res_wet;
                r_q0_nonwet <= w_res_nonwet;
            end else begin
                r_q0_wet    <= r_q1_wet;
                r_q0_nonwet <= r_q1_nonwet;
                r_q1_wet    <= w_res_wet;
                r_q1_nonwet <= w_res_nonwet;
            end
        end else if (w_pop) begin
            r_q0_wet    <= r_q1_wet;
            r_q0_nonwet <= r_q1_nonwet;
        end else if (w_push) begin
            if (r_cnt == 2'd0) begin
                r_q0_wet    <= w_res_wet;
                r_q0_nonwet <= w_res_nonwet;
            end else begin
                r_q1_wet    <= w_res_wet;
                r_q1_nonwet <= w_res_nonwet;
            end
        end
    end

    assign o_perm.valid       = (r_cnt != 2'd0);
    assign o_perm.perm_wet    = r_q0_wet;
    assign o_perm.perm_nonwet = r_q0_nonwet;

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[DEPTH-1] && r_cnt == 2'd2 && w_en) |-> o_perm.ready)
        else $error("result pushed into a full output buffer");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_sat.ready |-> (r_cnt == 2'd2 && !o_perm.ready))
        else $error("input stalled without a full output buffer");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_res_wet <= bcr_pkg::ONE15 && w_res_nonwet <= bcr_pkg::ONE15))
        else $error("result above one");
`endif
endmodule

@@ hw/rtl/bcr_div.sv @@
module bcr_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [bcr_pkg::NUM_W-1:0]    i_num,
    input  logic [bcr_pkg::DEN_W-1:0]    i_den,
    input  logic [15:0]                  i_nonwet_exp,
    output logic [15:0]                  o_s,
    output logic [bcr_pkg::EXP_W-1:0]    o_q
);
    localparam int SB     = bcr_pkg::SAT_BITS;
    localparam int NS     = bcr_pkg::DIV_STAGES;
    localparam int QW     = bcr_pkg::EXP_W;
    localparam int S_ST   = SB + 1 + 16;        // remainder and quotient bits
    localparam int Q_ST   = 16 + QW;
    localparam int Q_DBL  = QW - NS;            // stages that take two legacy steps

    // One restoring step of the normalized saturation
    function automatic logic [S_ST-1:0] f_sstep(input logic [S_ST-1:0] st,
                                                input logic [SB:0] d);
        logic [SB+1:0] t;
        logic [15:0]   q;
        logic          qb;
        t  = {st[S_ST-1:16], st[15]};
        q  = st[15:0];
        qb = (t >= {1'b0, d});
        if (qb) begin
            t = t - {1'b0, d};
        end
        return {t[SB:0], q[14:0], qb};
    endfunction

    // One restoring step of the legacy exponent
    function automatic logic [Q_ST-1:0] f_qstep(input logic [Q_ST-1:0] st,
                                                input logic [15:0] d);
        logic [16:0]   t;
        logic [QW-1:0] q;
        logic          qb;
        t  = {st[Q_ST-1:QW], st[QW-1]};
        q  = st[QW-1:0];
        qb = (t >= {1'b0, d});
        if (qb) begin
            t = t - {1'b0, d};
        end
        return {t[15:0], q[QW-2:0], qb};
    endfunction

    logic [S_ST-1:0] r_s [NS];
    logic [Q_ST-1:0] r_q [NS];
    logic [S_ST-1:0] w_s0;
    logic [Q_ST-1:0] w_q0;

    // Seed both dividers: 2^25 + b/2 over b for the legacy exponent
    assign w_s0 = i_num;
    assign w_q0 = {16'd0, 1'b1, (QW - 16)'(0), i_nonwet_exp[15:1]};

    for (genvar i = 0; i < NS; i++) begin : g_stage
        logic [S_ST-1:0] w_sin;
        logic [Q_ST-1:0] w_qin;
        logic [Q_ST-1:0] w_qmid;
        logic [Q_ST-1:0] w_qout;
        if (i == 0) begin : g_first
            assign w_sin = w_s0;
            assign w_qin = w_q0;
        end else begin : g_next
            assign w_sin = r_s[i-1];
            assign w_qin = r_q[i-1];
        end
        assign w_qmid = f_qstep(w_qin, i_nonwet_exp);
        if (i < Q_DBL) begin : g_two
            assign w_qout = f_qstep(w_qmid, i_nonwet_exp);
        end else begin : g_one
            assign w_qout = w_qmid;
        end
        // Advance one stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[i] <= f_sstep(w_sin, i_den);
                r_q[i] <= w_qout;
            end
        end
    end

    assign o_s = r_s[NS-1][15:0];
    assign o_q = r_q[NS-1][QW-1:0];
endmodule

@@ hw/rtl/bcr_pow.sv @@
module bcr_pow (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [bcr_pkg::X_W-1:0]      i_x,
    input  logic [bcr_pkg::EXP_W-1:0]    i_e,
    output logic [bcr_pkg::X_W-1:0]      o_y
);
    localparam int XW = bcr_pkg::X_W;
    localparam int EW = bcr_pkg::EXP_W;
    localparam int NL = 16;     // log2 fraction bits, one per stage
    localparam int NE = 16;     // exp2 fraction bits, one per stage
    localparam int PW = 21 + EW;

    // Log stage registers
    logic [30:0]   r_lm   [NL+1];
    logic [15:0]   r_lf   [NL+1];
    logic [4:0]    r_lint [NL+1];
    logic [EW-1:0] r_le   [NL+1];
    logic          r_lone [NL+1];
    logic          r_lzero[NL+1];

    // Product stage
    logic [PW-1:0] r_prod;
    logic          r_mone;
    logic          r_mzero;

    // Exp stage registers
    logic [32:0]   r_er   [NE+1];
    logic [15:0]   r_ef   [NE+1];
    logic [4:0]    r_ek   [NE+1];
    logic          r_eone [NE+1];
    logic          r_ezero[NE+1];

    logic [XW-1:0] r_y;

    // Normalize x to a Q1.30 mantissa
    logic [3:0]  w_p;
    logic [30:0] w_m0;
    always_comb begin
        w_p = '0;
        for (int i = 0; i < 16; i++) begin
            if (i_x[i]) begin
                w_p = 4'(i);
            end
        end
    end
    assign w_m0 = 31'(i_x[15:0]) << (5'd30 - {1'b0, w_p});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lm[0]    <= w_m0;
            r_lf[0]    <= '0;
            r_lint[0]  <= 5'd16 - {1'b0, w_p};
            r_le[0]    <= i_e;
            r_lone[0]  <= (i_e == '0) || i_x[XW-1];
            r_lzero[0] <= (i_x == '0);
        end
    end

    // Square the mantissa, take one fraction bit per stage
    for (genvar i = 0; i < NL; i++) begin : g_log
        logic [61:0] w_sq;
        logic [31:0] w_mm;
        assign w_sq = {31'd0, r_lm[i]} * {31'd0, r_lm[i]};
        assign w_mm = w_sq[61:30];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lm[i+1]    <= w_mm[31] ? w_mm[31:1] : w_mm[30:0];
                r_lf[i+1]    <= {r_lf[i][14:0], w_mm[31]};
                r_lint[i+1]  <= r_lint[i];
                r_le[i+1]    <= r_le[i];
                r_lone[i+1]  <= r_lone[i];
                r_lzero[i+1] <= r_lzero[i];
            end
        end
    end

    // Scale -log2(x) by the exponent
    logic [20:0] w_n;
    assign w_n = {r_lint[NL], 16'd0} - {5'd0, r_lf[NL]};
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= {EW'(0), w_n} * {21'd0, r_le[NL]};
            r_mone  <= r_lone[NL];
            r_mzero <= r_lzero[NL];
        end
    end

    // Round to Q.16, split into integer and fraction
    logic [PW-1:0] w_rnd;
    logic [PW-13:0] w_t;
    assign w_rnd = r_prod + PW'(2048);
    assign w_t   = w_rnd[PW-1:12];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_er[0]    <= 33'h1_0000_0000;
            r_ef[0]    <= w_t[15:0];
            r_ek[0]    <= w_t[20:16];
            r_eone[0]  <= r_mone;
            r_ezero[0] <= r_mzero || (w_t >= (PW-12)'(17 * 65536));
        end
    end

    // Multiply in one root-of-one-half factor per fraction bit
    for (genvar j = 0; j < NE; j++) begin : g_exp
        localparam logic [31:0] C_J = bcr_pkg::f_exp_coef(j + 1);
        logic [64:0] w_pr;
        assign w_pr = {32'd0, r_er[j]} * {33'd0, C_J};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_er[j+1]    <= r_ef[j][NE-1-j] ? w_pr[64:32] : r_er[j];
                r_ef[j+1]    <= r_ef[j];
                r_ek[j+1]    <= r_ek[j];
                r_eone[j+1]  <= r_eone[j];
                r_ezero[j+1] <= r_ezero[j];
            end
        end
    end

    // Round and shift by the integer part
    logic [5:0]  w_sh;
    logic [33:0] w_sum;
    logic [33:0] w_v;
    assign w_sh  = 6'd16 + {1'b0, r_ek[NE]};
    assign w_sum = {1'b0, r_er[NE]} + (34'd1 << (w_sh - 6'd1));
    assign w_v   = w_sum >> w_sh;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_eone[NE]) begin
                r_y <= bcr_pkg::ONE16;
            end else if (r_ezero[NE]) begin
                r_y <= '0;
            end else if (w_v > 34'(bcr_pkg::ONE16)) begin
                r_y <= bcr_pkg::ONE16;
            end else begin
                r_y <= w_v[XW-1:0];
            end
        end
    end

    assign o_y = r_y;
endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import bcr_pkg::*;

    localparam int LATENCY   = 56;
    localparam int MAX_CYCLE = 1500000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [2:0]          i_cfg_idx;
    logic [CFG_W-1:0]    i_cfg_data;

    bcr_sat_if  sat_ch ();
    bcr_perm_if perm_ch ();

    brooks_corey_relperm u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sat      (sat_ch.sink),
        .o_perm     (perm_ch.source)
    );

    // Shadow copy of the relperm registers
    logic [15:0]         exp_wet;
    logic [15:0]         exp_nonwet;
    logic [SAT_BITS-1:0] resid_sat;
    logic [15:0]         end_wet;
    logic [15:0]         end_nonwet;
    logic                legacy;

    logic [15:0] perm_wet_q[$];
    logic [15:0] perm_nonwet_q[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          err_cnt;
    longint      cycle_cnt;
    logic [63:0] root_coef[17];

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Bit-serial square root on 64-bit operands
    function automatic logic [63:0] sqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = '0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // x^e with x in Q0.16 and e in Q.12, through log2 and exp2
    function automatic logic [63:0] pow_q16(input logic [63:0] x, input logic [63:0] e);
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] nlog;
        logic [63:0] t;
        logic [63:0] f;
        logic [63:0] r;
        int          msb;
        int          k;
        if (e == 0 || x >= 64'd65536) return 64'd65536;
        if (x == 0) return 64'd0;
        msb = 0;
        for (int i = 0; i < 16; i++) if (x[i]) msb = i;
        m    = x << (30 - msb);
        frac = 0;
        for (int i = 0; i < 16; i++) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                frac = frac | 64'd1;
                m    = m >> 1;
            end
        end
        nlog = (64'(16 - msb) << 16) - frac;
        t    = (nlog * e + 64'd2048) >> 12;
        if (t >= (64'd17 << 16)) return 64'd0;
        k = int'(t >> 16);
        f = t & 64'hFFFF;
        r = 64'd1 << 32;
        for (int j = 1; j <= 16; j++) if (f[16-j]) r = (r * root_coef[j]) >> 32;
        r = (r + (64'd1 << (15 + k))) >> (16 + k);
        return (r > 64'd65536) ? 64'd65536 : r;
    endfunction

    function automatic logic [15:0] apply_endpoint(input logic [15:0] ep, input logic [63:0] p);
        logic [63:0] v;
        v = ((ep > 16'd32768 ? 64'd32768 : 64'(ep)) * p + 64'd32768) >> 16;
        return (v > 64'd32768) ? 16'd32768 : v[15:0];
    endfunction

    // Predict both permeabilities for one saturation beat
    task automatic predict_relperm(input logic [SAT_BITS-1:0] sw);
        logic [63:0] diff;
        logic [63:0] den;
        logic [63:0] s;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] sq;
        logic [63:0] q;
        logic [63:0] pn;
        if (sw <= resid_sat) begin
            perm_wet_q.push_back(16'd0);
            perm_nonwet_q.push_back(end_nonwet > 16'd32768 ? 16'd32768 : end_nonwet);
            return;
        end
        diff = 64'(sw) - 64'(resid_sat);
        den  = (64'd1 << SAT_BITS) - 64'(resid_sat);
        s    = ((diff << 16) + den / 2) / den;
        if (s > 64'd65536) s = 64'd65536;
        perm_wet_q.push_back(apply_endpoint(end_wet, pow_q16(s, 64'(exp_wet))));
        if (legacy) begin
            u  = 64'd65536 - s;
            u2 = (u * u + 64'd32768) >> 16;
            sq = 0;
            if (exp_nonwet != 0) begin
                q  = 64'd4096 + ((64'd1 << 25) + 64'(exp_nonwet) / 2) / 64'(exp_nonwet);
                sq = pow_q16(s, q);
            end
            pn = (u2 * (64'd65536 - sq) + 64'd32768) >> 16;
        end else begin
            pn = pow_q16(64'd65536 - s, 64'(exp_nonwet));
        end
        perm_nonwet_q.push_back(apply_endpoint(end_nonwet, pn));
    endtask

    // Write one register while the pipeline is idle; the caller drops the enable
    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(val);
        @(posedge i_clk);
        case (idx)
            CFG_WET_EXP:    exp_wet    = val;
            CFG_NONWET_EXP: exp_nonwet = val;
            CFG_RESID:      resid_sat  = val[SAT_BITS-1:0];
            CFG_WET_END:    end_wet    = val;
            CFG_NONWET_END: end_nonwet = val;
            CFG_LEGACY:     legacy     = val[0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [15:0] a, input logic [15:0] b, input logic [15:0] r,
                             input logic [15:0] kw, input logic [15:0] kn, input logic lg);
        write_reg(CFG_WET_EXP, a);
        write_reg(CFG_NONWET_EXP, b);
        write_reg(CFG_RESID, r);
        write_reg(CFG_WET_END, kw);
        write_reg(CFG_NONWET_END, kn);
        write_reg(CFG_LEGACY, 16'(lg));
        i_cfg_we <= 1'b0;
    endtask

    // Send one saturation beat, idling at random first; valid stays high after it
    task automatic send_sat(input logic [SAT_BITS-1:0] sw);
        while ($urandom_range(99) < send_idle_pct) begin
            sat_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sat_ch.valid      <= 1'b1;
        sat_ch.saturation <= sw;
        predict_relperm(sw);
        @(posedge i_clk);
        while (!sat_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        sat_ch.valid <= 1'b0;
        while (perm_wet_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    function automatic logic [SAT_BITS-1:0] rand_sat();
        case ($urandom_range(5))
            0: return SAT_BITS'($urandom_range(32));
            1: return SAT_BITS'(65535 - $urandom_range(32));
            2: return SAT_BITS'(resid_sat + $urandom_range(4) - 2);
            default: return SAT_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_exp();
        case ($urandom_range(5))
            0: return 16'($urandom_range(1, 16));
            1: return 16'(65535 - $urandom_range(16));
            2: return 16'($urandom_range(4096, 20480));
            3: return 16'd0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_end();
        case ($urandom_range(3))
            0: return 16'd32768;
            1: return 16'($urandom);
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    // Defaults after reset: quadratic forms, no residual
    task automatic test_reset_defaults();
        send_sat('0);
        send_sat(SAT_BITS'(1));
        send_sat(SAT_BITS'(32768));
        send_sat('1);
        drain();
    endtask

    // Exponent and endpoint extremes, residual boundary, legacy with zero exponent
    task automatic test_directed_corners();
        write_all(16'd1, 16'd65535, 16'd16384, 16'd65535, 16'd40000, 1'b0);
        send_sat(SAT_BITS'(16383));
        send_sat(SAT_BITS'(16384));
        send_sat(SAT_BITS'(16385));
        send_sat('1);
        send_sat(SAT_BITS'(21845));
        drain();
        write_all(16'd0, 16'd0, 16'd65535, 16'd0, 16'd0, 1'b0);
        send_sat('1);
        send_sat(SAT_BITS'(65534));
        drain();
        write_all(16'd65535, 16'd0, 16'd0, 16'd32768, 16'd32768, 1'b1);
        send_sat(SAT_BITS'(1));
        send_sat(SAT_BITS'(43690));
        send_sat('1);
        drain();
        write_all(16'd12288, 16'd1, 16'd100, 16'd32767, 16'd65535, 1'b1);
        send_sat(SAT_BITS'(101));
        send_sat(SAT_BITS'(30000));
        send_sat(SAT_BITS'(65000));
        drain();
    endtask

    // Random saturations over random register settings
    task automatic test_random_sweep(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++) begin
            write_all(rand_exp(), rand_exp(), $urandom_range(3) == 0 ? 16'd0 : 16'($urandom),
                      rand_end(), rand_end(), 1'($urandom));
            for (int i = 0; i < per_phase; i++) send_sat(rand_sat());
            drain();
        end
    endtask

    // Hold the sender until every pending result is back, then resume
    task automatic test_pause_until_drained();
        for (int i = 0; i < 30; i++) send_sat(SAT_BITS'($urandom));
        sat_ch.valid <= 1'b0;
        while (perm_wet_q.size() != 0) @(posedge i_clk);
        for (int i = 0; i < 30; i++) send_sat(SAT_BITS'($urandom));
        drain();
    endtask

    // Randomize the receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            perm_ch.ready <= 1'b0;
        end else begin
            perm_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && perm_ch.valid && perm_ch.ready) begin
            if (perm_wet_q.size() == 0) begin
                $display("%0t: unexpected beat wet=%0d nonwet=%0d", $time,
                         perm_ch.perm_wet, perm_ch.perm_nonwet);
                err_cnt++;
            end else begin
                if (perm_ch.perm_wet !== perm_wet_q[0]) begin
                    $display("%0t: perm_wet expected %0d actual %0d", $time,
                             perm_wet_q[0], perm_ch.perm_wet);
                    err_cnt++;
                end
                if (perm_ch.perm_nonwet !== perm_nonwet_q[0]) begin
                    $display("%0t: perm_nonwet expected %0d actual %0d", $time,
                             perm_nonwet_q[0], perm_ch.perm_nonwet);
                    err_cnt++;
                end
                void'(perm_wet_q.pop_front());
                void'(perm_nonwet_q.pop_front());
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > MAX_CYCLE) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_WET_EXP;
        i_cfg_data        = '0;
        sat_ch.valid      = 1'b0;
        sat_ch.saturation = '0;
        err_cnt           = 0;
        cycle_cnt         = 0;
        send_idle_pct     = 28;
        recv_idle_pct     = 79;
        exp_wet           = 16'd8192;
        exp_nonwet        = 16'd8192;
        resid_sat         = '0;
        end_wet           = 16'd32768;
        end_nonwet        = 16'd32768;
        legacy            = 1'b0;
        root_coef[0] = 64'd1 << 31;
        for (int j = 1; j <= 16; j++) root_coef[j] = sqrt64(root_coef[j-1] << 32);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_corners();
        test_random_sweep(10, 60);
        test_pause_until_drained();
        send_idle_pct = 79;
        recv_idle_pct = 28;
        test_random_sweep(10, 60);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_sweep(10, 60);

        drain();
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
